### design/trapezoid_speed_profile_unit_defines.svh
// ----------------------------------------------------------------------------
// Trapezoid speed profile - assertion macros
// Shared concurrent check macros, clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_SPEED_PROFILE_UNIT_DEFINES_SVH
`define TRAPEZOID_SPEED_PROFILE_UNIT_DEFINES_SVH

// same-cycle implication
`define TSP_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid speed profile - package
// Widths, codes and the elaboration-time sigmoid table builder.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int LEVEL_W        = FRAC_BITS + 1;
    localparam int SEG_W          = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int CNT_W          = $clog2(FRAC_BITS + 1);
    localparam int COUNT_BITS_DEF = 16;
    localparam int TABLE_BITS_DEF = 8;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [63:0]        Q30_ONE    = 64'd1 << 30;

    typedef enum logic [SEG_W-1:0] {
        SEG_UP   = 2'd0,
        SEG_HOLD = 2'd1,
        SEG_DOWN = 2'd2,
        SEG_END  = 2'd3
    } t_seg;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAMP_UP    = 2'd0,
        REG_HOLD       = 2'd1,
        REG_RAMP_DOWN  = 2'd2,
        REG_CURVE_MODE = 2'd3
    } t_cfg_reg;

    // shift-subtract quotient, constant arguments only
    function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // entry k of a 2^tbits sigmoid(6*(t-0.5)) table, Q1.FRAC_BITS
    function automatic logic [63:0] sig_entry(input int unsigned k, input int unsigned tbits);
        logic [63:0] kk;
        logic [63:0] half;
        logic [63:0] offs;
        logic [63:0] a;
        logic [63:0] z;
        logic [63:0] p;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] s;
        int          n;
        int          r;
        kk   = 64'(k);
        half = 64'd1 << (tbits - 1);
        offs = (kk >= half) ? (kk - half) : (half - kk);
        a    = (64'd6 * offs) << (30 - tbits);
        z    = a >> 4;
        p    = Q30_ONE;
        for (n = 7; n >= 1; n--) begin
            p = Q30_ONE - div64((z * p) >> 30, 64'(n));
        end
        e = p;
        for (r = 0; r < 4; r++) begin
            e = (e * e) >> 30;
        end
        d = Q30_ONE + e;
        s = div64((64'd1 << (FRAC_BITS + 30)) + (d >> 1), d);
        return (kk >= half) ? s : (64'(FULL_LEVEL) - s);
    endfunction

endpackage

### design/tsp_ifs.sv
// ----------------------------------------------------------------------------
// Trapezoid speed profile - channel interfaces
// Tick input, profile point output and register write channels.
// ----------------------------------------------------------------------------
interface tsp_in_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink   (input valid, input start_req, output ready);
endinterface

interface tsp_out_if;
    logic                           valid;
    logic                           ready;
    logic [tsp_pkg::LEVEL_W-1:0]    level;
    logic [tsp_pkg::SEG_W-1:0]      segment;
    logic                           last;

    modport source (output valid, output level, output segment, output last, input ready);
    modport sink   (input valid, input level, input segment, input last, output ready);
endinterface

interface tsp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tsp_pkg::CFG_IDX_W-1:0]  index;
    logic [tsp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/trapezoid_speed_profile_unit.sv
// ----------------------------------------------------------------------------
// Trapezoid speed profile unit
// Emits one point of a ramp-up / hold / ramp-down profile per productive tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : register writes (ramp up, hold, ramp down lengths, curve mode),
//            always ready; write only while no tick is in flight.
//   i_in   : one tick beat; start_req restarts the profile. A tick while idle
//            and not starting produces no point.
//   o_out  : one point per productive tick: level (Q1.16), segment, last.
// Steps: a tick steps past each empty or finished segment, then takes
//   FRAC_BITS (linear) or TABLE_BITS (smooth) quotient bits from the
//   one-bit-per-cycle ramp divider, then loads the output register. Hold
//   points skip the divider. The next tick is taken once the point is loaded.
// Throughput: one tick at a time; the divider sets the rate.
// Stall: the output register holds a finished point; the next tick is taken
//   and worked on, and waits before the output load until the slot frees.
// Reset: profile idle, config registers zero, output empty.
// ----------------------------------------------------------------------------
`include "trapezoid_speed_profile_unit_defines.svh"

module trapezoid_speed_profile_unit #(
    parameter int COUNT_BITS = tsp_pkg::COUNT_BITS_DEF,
    parameter int TABLE_BITS = tsp_pkg::TABLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tsp_cfg_if.sink          i_cfg,
    tsp_in_if.sink           i_in,
    tsp_out_if.source        o_out
);

    localparam int CW         = COUNT_BITS;
    localparam int FB         = tsp_pkg::FRAC_BITS;
    localparam int LW         = tsp_pkg::LEVEL_W;
    localparam int CNTW       = tsp_pkg::CNT_W;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SKIP,
        S_DIV,
        S_DONE
    } t_state;

    // sigmoid table, constant
    logic [LW-1:0] w_sig [TABLE_SIZE];

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_sig
        localparam logic [LW-1:0] SIG_K = LW'(tsp_pkg::sig_entry(k, TABLE_BITS));
        assign w_sig[k] = SIG_K;
    end

    // registers
    logic [tsp_pkg::CFG_DATA_W-1:0] r_ramp_up;
    logic [tsp_pkg::CFG_DATA_W-1:0] r_hold;
    logic [tsp_pkg::CFG_DATA_W-1:0] r_ramp_down;
    logic                           r_curve;

    t_state                r_state;
    logic                  r_run;
    tsp_pkg::t_seg         r_phase;
    logic [CW-1:0]         r_idx;
    tsp_pkg::t_seg         r_seg;
    logic [CW-1:0]         r_len;
    logic                  r_last_q;
    logic [CW:0]           r_rem;
    logic [FB-1:0]         r_quo;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_out_valid;
    logic [LW-1:0]         r_level;
    tsp_pkg::t_seg         r_segment;
    logic                  r_last;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_up   <= '0;
            r_hold      <= '0;
            r_ramp_down <= '0;
            r_curve     <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (tsp_pkg::t_cfg_reg'(i_cfg.index))
                tsp_pkg::REG_RAMP_UP:    r_ramp_up   <= i_cfg.data;
                tsp_pkg::REG_HOLD:       r_hold      <= i_cfg.data;
                tsp_pkg::REG_RAMP_DOWN:  r_ramp_down <= i_cfg.data;
                tsp_pkg::REG_CURVE_MODE: r_curve     <= i_cfg.data[0];
            endcase
        end
    end

    // segment lookup
    logic [CW-1:0] w_len;
    logic          w_hold_nz;
    logic          w_down_nz;
    logic          w_last_seg;
    logic          w_hit;
    logic [CW:0]   n_idx_inc;
    logic          w_seg_end;
    logic          w_last;

    assign w_hold_nz = CW'(r_hold) != '0;
    assign w_down_nz = CW'(r_ramp_down) != '0;

    always_comb begin
        unique case (r_phase)
            tsp_pkg::SEG_UP: begin
                w_len      = CW'(r_ramp_up);
                w_last_seg = !w_hold_nz && !w_down_nz;
            end
            tsp_pkg::SEG_HOLD: begin
                w_len      = CW'(r_hold);
                w_last_seg = !w_down_nz;
            end
            tsp_pkg::SEG_DOWN: begin
                w_len      = CW'(r_ramp_down);
                w_last_seg = 1'b1;
            end
            tsp_pkg::SEG_END: begin
                w_len      = '0;
                w_last_seg = 1'b0;
            end
        endcase
    end

    assign w_hit     = r_idx < w_len;
    assign n_idx_inc = {1'b0, r_idx} + (CW+1)'(1);
    assign w_seg_end = n_idx_inc == {1'b0, w_len};
    assign w_last    = w_seg_end && w_last_seg;

    // divider step
    logic [CW:0]   w_len_ext;
    logic [CW:0]   w_shift;
    logic          w_qbit;
    logic [CW:0]   n_rem;

    assign w_len_ext = {1'b0, r_len};
    assign w_shift   = {r_rem[CW-1:0], 1'b0};
    assign w_qbit    = w_shift >= w_len_ext;
    assign n_rem     = w_qbit ? (w_shift - w_len_ext) : w_shift;

    // point level
    logic [LW-1:0] w_ramp;
    logic [LW-1:0] w_level;

    assign w_ramp = r_curve ? w_sig[r_quo[TABLE_BITS-1:0]] : {1'b0, r_quo};

    always_comb begin
        unique case (r_seg)
            tsp_pkg::SEG_UP:   w_level = w_ramp;
            tsp_pkg::SEG_HOLD: w_level = tsp_pkg::FULL_LEVEL;
            tsp_pkg::SEG_DOWN: w_level = tsp_pkg::FULL_LEVEL - w_ramp;
            tsp_pkg::SEG_END:  w_level = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= 1'b0;
            r_phase     <= tsp_pkg::SEG_UP;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.start_req) begin
                            r_run   <= 1'b1;
                            r_phase <= tsp_pkg::SEG_UP;
                            r_idx   <= '0;
                            r_state <= S_SKIP;
                        end else if (r_run) begin
                            r_state <= S_SKIP;
                        end
                    end
                end
                S_SKIP: begin
                    if (r_phase == tsp_pkg::SEG_END) begin
                        r_run   <= 1'b0;
                        r_phase <= tsp_pkg::SEG_UP;
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else if (!w_hit) begin
                        r_phase <= tsp_pkg::t_seg'(r_phase + 2'd1);
                        r_idx   <= '0;
                    end else begin
                        r_seg    <= r_phase;
                        r_len    <= w_len;
                        r_last_q <= w_last;
                        r_rem    <= {1'b0, r_idx};
                        r_cnt    <= r_curve ? CNTW'(TABLE_BITS) : CNTW'(FB);
                        r_state  <= (r_phase == tsp_pkg::SEG_HOLD) ? S_DONE : S_DIV;
                        if (w_last) begin
                            r_run   <= 1'b0;
                            r_phase <= tsp_pkg::SEG_UP;
                            r_idx   <= '0;
                        end else if (w_seg_end) begin
                            r_phase <= tsp_pkg::t_seg'(r_phase + 2'd1);
                            r_idx   <= '0;
                        end else begin
                            r_idx <= n_idx_inc[CW-1:0];
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[FB-2:0], w_qbit};
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_level     <= w_level;
                        r_segment   <= r_seg;
                        r_last      <= r_last_q;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_cfg.ready   = 1'b1;
    assign i_in.ready    = r_state == S_IDLE;
    assign o_out.valid   = r_out_valid;
    assign o_out.level   = r_level;
    assign o_out.segment = tsp_pkg::SEG_W'(r_segment);
    assign o_out.last    = r_last;

    // checks
    `TSP_CHECK(a_rem_below_len, r_state == S_DIV, r_rem < w_len_ext, "divider remainder out of range")
    `TSP_CHECK(a_div_ramp_only, r_state == S_DIV, r_seg != tsp_pkg::SEG_HOLD, "divider busy on hold point")
    `TSP_CHECK(a_idle_phase, r_state == S_IDLE, r_phase != tsp_pkg::SEG_END, "finished phase left at idle")
    `TSP_CHECK(a_stopped_clear, !r_run, r_phase == tsp_pkg::SEG_UP && r_idx == '0, "stopped profile not rewound")
    `TSP_CHECK_NEXT(a_div_done, r_state == S_DIV && r_cnt == CNTW'(1), r_state == S_DONE, "divider overran")

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Trapezoid speed profile unit - testbench
// Drives tick beats and register writes with random gaps and output stalls.
// A directed table comes first, then randomised phases of settings. Every
// point beat is compared field by field against a typed expected point or an
// in-bench profile predictor.
module testbench;

    localparam int CYCLE_LIMIT    = 5_000_000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LEVEL_W        = tsp_pkg::LEVEL_W;
    localparam int SEG_W          = tsp_pkg::SEG_W;
    localparam int CFG_DATA_W     = tsp_pkg::CFG_DATA_W;
    localparam int FRAC_BITS      = tsp_pkg::FRAC_BITS;
    localparam int TABLE_BITS_DEF = tsp_pkg::TABLE_BITS_DEF;
    localparam int LUT_SIZE       = 1 << TABLE_BITS_DEF;
    localparam int PHASES         = 12;
    localparam int PHASE_POINTS   = 170;
    localparam int PHASE_TICKS    = 400;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = tsp_pkg::FULL_LEVEL;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SEG_W-1:0]   seg;
        logic               last;
    } t_point;

    typedef enum {ROW_CFG, ROW_TICK} t_row_kind;
    typedef enum {WANT_MODEL, WANT_NONE, WANT_POINT} t_want;

    typedef struct {
        t_row_kind             kind;
        tsp_pkg::t_cfg_reg     idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    start;
        t_want                 want;
        t_point                pt;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsp_cfg_if reg_ch();
    tsp_in_if  tick_ch();
    tsp_out_if point_ch();

    trapezoid_speed_profile_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (reg_ch),
        .i_in    (tick_ch),
        .o_out   (point_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and register shadows
    logic [LEVEL_W-1:0]    sig_lut [LUT_SIZE];
    logic [CFG_DATA_W-1:0] len_up;
    logic [CFG_DATA_W-1:0] len_hold;
    logic [CFG_DATA_W-1:0] len_down;
    bit                    smooth_cfg;
    bit                    prof_running;
    tsp_pkg::t_seg         prof_seg;
    logic [CFG_DATA_W-1:0] prof_idx;

    t_point pending_points [$];
    t_want  tick_want;
    t_point tick_typed;
    t_row   directed_rows [$];

    int  mismatches;
    int  points_checked;
    int  points_expected;
    int  ticks_taken;
    int  cfg_writes;
    int  settings_run;
    int  cycle_count;
    int  stall_left;
    bit  idle_on;

    function automatic logic [LEVEL_W-1:0] sigmoid_point(input int unsigned k);
        logic [63:0] one30;
        logic [63:0] half;
        logic [63:0] offs;
        logic [63:0] a;
        logic [63:0] z;
        logic [63:0] p;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] s;
        int          n;
        int          r;
        one30 = 64'd1 << 30;
        half  = 64'd1 << (TABLE_BITS_DEF - 1);
        offs  = (64'(k) >= half) ? (64'(k) - half) : (half - 64'(k));
        a     = (64'd6 * offs) << (30 - TABLE_BITS_DEF);
        z     = a >> 4;
        p     = one30;
        for (n = 7; n >= 1; n--) begin
            p = one30 - ((z * p) >> 30) / 64'(n);
        end
        e = p;
        for (r = 0; r < 4; r++) begin
            e = (e * e) >> 30;
        end
        d = one30 + e;
        s = ((64'd1 << (FRAC_BITS + 30)) + d / 64'd2) / d;
        if (64'(k) < half) begin
            s = (64'd1 << FRAC_BITS) - s;
        end
        return s[LEVEL_W-1:0];
    endfunction

    function automatic logic [CFG_DATA_W-1:0] seg_len(input tsp_pkg::t_seg s);
        case (s)
            tsp_pkg::SEG_UP:   return len_up;
            tsp_pkg::SEG_HOLD: return len_hold;
            tsp_pkg::SEG_DOWN: return len_down;
            default:           return '0;
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] ramp_level(input logic [CFG_DATA_W-1:0] i,
                                                      input logic [CFG_DATA_W-1:0] n);
        logic [63:0] q;
        if (smooth_cfg) begin
            q = (64'(i) << TABLE_BITS_DEF) / 64'(n);
            return sig_lut[q[TABLE_BITS_DEF-1:0]];
        end
        q = (64'(i) << FRAC_BITS) / 64'(n);
        return q[LEVEL_W-1:0];
    endfunction

    // advances the profile by one tick; returns 1 when a point is emitted
    function automatic bit predict_point(input bit start, output t_point pt);
        logic [CFG_DATA_W-1:0] n;
        logic [CFG_DATA_W-1:0] i;
        logic [CFG_DATA_W:0]   nxt;
        logic [LEVEL_W-1:0]    lvl;
        tsp_pkg::t_seg         s;
        bit                    fin;
        int                    q;
        pt = '0;
        if (start) begin
            prof_running = 1'b1;
            prof_seg     = tsp_pkg::SEG_UP;
            prof_idx     = '0;
        end
        if (!prof_running) begin
            return 1'b0;
        end
        while (prof_seg != tsp_pkg::SEG_END && prof_idx >= seg_len(prof_seg)) begin
            prof_seg = tsp_pkg::t_seg'(int'(prof_seg) + 1);
            prof_idx = '0;
        end
        if (prof_seg == tsp_pkg::SEG_END) begin
            prof_running = 1'b0;
            prof_seg     = tsp_pkg::SEG_UP;
            prof_idx     = '0;
            return 1'b0;
        end
        s = prof_seg;
        i = prof_idx;
        n = seg_len(s);
        case (s)
            tsp_pkg::SEG_UP:   lvl = ramp_level(i, n);
            tsp_pkg::SEG_HOLD: lvl = FULL_LEVEL;
            default:           lvl = FULL_LEVEL - ramp_level(i, n);
        endcase
        nxt = {1'b0, i} + 1'b1;
        fin = (nxt >= {1'b0, n});
        for (q = int'(s) + 1; q <= int'(tsp_pkg::SEG_DOWN); q++) begin
            if (seg_len(tsp_pkg::t_seg'(q)) != 0) begin
                fin = 1'b0;
            end
        end
        if (nxt >= {1'b0, n}) begin
            prof_seg = tsp_pkg::t_seg'(int'(s) + 1);
            prof_idx = '0;
        end else begin
            prof_idx = nxt[CFG_DATA_W-1:0];
        end
        if (fin) begin
            prof_running = 1'b0;
            prof_seg     = tsp_pkg::SEG_UP;
            prof_idx     = '0;
        end
        pt.level = lvl;
        pt.seg   = s;
        pt.last  = fin;
        return 1'b1;
    endfunction

    function automatic int pick_delay();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return '0;
        end
        if (r < 70) begin
            return CFG_DATA_W'($urandom_range(1, 8));
        end
        if (r < 88) begin
            return CFG_DATA_W'($urandom_range(9, 300));
        end
        if (r < 94) begin
            return '1;
        end
        return CFG_DATA_W'($urandom);
    endfunction

    task automatic report(input string field, input longint exp_v, input longint act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at point %0d: %s expected %0d got %0d",
                     points_checked, field, exp_v, act_v);
        end
    endtask

    task automatic add_cfg(input tsp_pkg::t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.start = 1'b0;
        row.want  = WANT_NONE;
        row.pt    = '0;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_tick(input bit start, input t_want want,
                            input logic [LEVEL_W-1:0] level, input tsp_pkg::t_seg seg,
                            input bit last);
        t_row row;
        row.kind     = ROW_TICK;
        row.idx      = tsp_pkg::REG_RAMP_UP;
        row.data     = '0;
        row.start    = start;
        row.want     = want;
        row.pt.level = level;
        row.pt.seg   = seg;
        row.pt.last  = last;
        directed_rows = {directed_rows, row};
    endtask

    task automatic write_reg(input tsp_pkg::t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        reg_ch.index = idx;
        reg_ch.data  = data;
        reg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!reg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        reg_ch.valid = 1'b0;
        cfg_writes++;
    endtask

    task automatic drive_tick(input bit start, input t_want want, input t_point typed);
        int gap;
        gap = pick_delay();
        if (gap > 0) begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_want         = want;
        tick_typed        = typed;
        tick_ch.start_req = start;
        tick_ch.valid     = 1'b1;
        @(posedge i_clk);
        while (!tick_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // all points in, then room for a tick that yields nothing
    task automatic wait_drained();
        tick_ch.valid = 1'b0;
        while (pending_points.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : monitor
        t_point pt;
        t_point exp_pt;
        bit     got;
        if (i_rst_n) begin
            if (reg_ch.valid && reg_ch.ready) begin
                case (tsp_pkg::t_cfg_reg'(reg_ch.index))
                    tsp_pkg::REG_RAMP_UP:    len_up     = reg_ch.data;
                    tsp_pkg::REG_HOLD:       len_hold   = reg_ch.data;
                    tsp_pkg::REG_RAMP_DOWN:  len_down   = reg_ch.data;
                    tsp_pkg::REG_CURVE_MODE: smooth_cfg = reg_ch.data[0];
                    default: ;
                endcase
            end
            if (tick_ch.valid && tick_ch.ready) begin
                got = predict_point(tick_ch.start_req, pt);
                ticks_taken++;
                if (tick_want == WANT_POINT) begin
                    pending_points = {pending_points, tick_typed};
                    points_expected++;
                end else if (tick_want == WANT_MODEL && got) begin
                    pending_points = {pending_points, pt};
                    points_expected++;
                end
            end
            if (point_ch.valid && point_ch.ready) begin
                if (pending_points.size() == 0) begin
                    report("unexpected beat, level", -1, point_ch.level);
                end else begin
                    exp_pt = pending_points.pop_front();
                    if (point_ch.level !== exp_pt.level) begin
                        report("level", exp_pt.level, point_ch.level);
                    end
                    if (point_ch.segment !== exp_pt.seg) begin
                        report("segment", exp_pt.seg, point_ch.segment);
                    end
                    if (point_ch.last !== exp_pt.last) begin
                        report("last", exp_pt.last, point_ch.last);
                    end
                end
                points_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // sink side: random back-pressure
    initial begin
        point_ch.ready = 1'b0;
        stall_left     = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                point_ch.ready = 1'b0;
                stall_left--;
            end else begin
                point_ch.ready = 1'b1;
                stall_left     = pick_delay();
            end
        end
    end

    initial begin : stimulus
        int     k;
        int     ph;
        int     phase_base;
        int     phase_ticks;
        bit     start;
        t_point none_pt;

        i_rst_n           = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.start_req = 1'b0;
        reg_ch.valid      = 1'b0;
        reg_ch.index      = tsp_pkg::REG_RAMP_UP;
        reg_ch.data       = '0;
        tick_want         = WANT_MODEL;
        tick_typed        = '0;
        none_pt           = '0;
        len_up            = '0;
        len_hold          = '0;
        len_down          = '0;
        smooth_cfg        = 1'b0;
        prof_running      = 1'b0;
        prof_seg          = tsp_pkg::SEG_UP;
        prof_idx          = '0;
        idle_on           = 1'b1;
        for (k = 0; k < LUT_SIZE; k++) begin
            sig_lut[k] = sigmoid_point(k);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle tick, then a start with every length zero
        add_tick(1'b0, WANT_NONE, '0, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b1, WANT_NONE, '0, tsp_pkg::SEG_UP, 1'b0);
        add_cfg(tsp_pkg::REG_RAMP_UP, 16'd2);
        add_cfg(tsp_pkg::REG_HOLD, 16'd1);
        add_cfg(tsp_pkg::REG_RAMP_DOWN, 16'd2);
        add_tick(1'b1, WANT_POINT, 17'd0, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_POINT, 17'd32768, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_POINT, FULL_LEVEL, tsp_pkg::SEG_HOLD, 1'b0);
        // restart while running
        add_tick(1'b1, WANT_POINT, 17'd0, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_POINT, 17'd32768, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_POINT, FULL_LEVEL, tsp_pkg::SEG_HOLD, 1'b0);
        add_tick(1'b0, WANT_POINT, FULL_LEVEL, tsp_pkg::SEG_DOWN, 1'b0);
        add_tick(1'b0, WANT_POINT, 17'd32768, tsp_pkg::SEG_DOWN, 1'b1);
        add_tick(1'b0, WANT_NONE, '0, tsp_pkg::SEG_UP, 1'b0);
        // empty hold segment is skipped
        add_cfg(tsp_pkg::REG_HOLD, 16'd0);
        add_tick(1'b1, WANT_POINT, 17'd0, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_POINT, 17'd32768, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_POINT, FULL_LEVEL, tsp_pkg::SEG_DOWN, 1'b0);
        // lengths changed mid-profile
        add_cfg(tsp_pkg::REG_RAMP_UP, 16'hFFFF);
        add_tick(1'b0, WANT_POINT, 17'd32768, tsp_pkg::SEG_DOWN, 1'b1);
        add_cfg(tsp_pkg::REG_CURVE_MODE, 16'd1);
        add_cfg(tsp_pkg::REG_RAMP_DOWN, 16'd0);
        add_tick(1'b1, WANT_MODEL, '0, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_MODEL, '0, tsp_pkg::SEG_UP, 1'b0);
        add_cfg(tsp_pkg::REG_HOLD, 16'hFFFF);
        add_cfg(tsp_pkg::REG_RAMP_DOWN, 16'hFFFF);
        add_tick(1'b1, WANT_MODEL, '0, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_MODEL, '0, tsp_pkg::SEG_UP, 1'b0);
        // ramp-up shrunk below the current step
        add_cfg(tsp_pkg::REG_RAMP_UP, 16'd0);
        add_tick(1'b0, WANT_POINT, FULL_LEVEL, tsp_pkg::SEG_HOLD, 1'b0);
        add_cfg(tsp_pkg::REG_CURVE_MODE, 16'd0);
        add_cfg(tsp_pkg::REG_RAMP_UP, 16'd1);
        add_cfg(tsp_pkg::REG_HOLD, 16'd0);
        add_cfg(tsp_pkg::REG_RAMP_DOWN, 16'd1);
        add_tick(1'b1, WANT_POINT, 17'd0, tsp_pkg::SEG_UP, 1'b0);
        add_tick(1'b0, WANT_POINT, FULL_LEVEL, tsp_pkg::SEG_DOWN, 1'b1);
        add_tick(1'b0, WANT_NONE, '0, tsp_pkg::SEG_UP, 1'b0);

        settings_run = 1;
        for (k = 0; k < directed_rows.size(); k++) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[k].idx, directed_rows[k].data);
                settings_run++;
            end else begin
                drive_tick(directed_rows[k].start, directed_rows[k].want,
                           directed_rows[k].pt);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 0) begin
                write_reg(tsp_pkg::REG_RAMP_UP, '1);
                write_reg(tsp_pkg::REG_HOLD, '1);
                write_reg(tsp_pkg::REG_RAMP_DOWN, '1);
                write_reg(tsp_pkg::REG_CURVE_MODE, 16'd1);
            end else begin
                write_reg(tsp_pkg::REG_RAMP_UP, pick_length());
                write_reg(tsp_pkg::REG_HOLD, pick_length());
                write_reg(tsp_pkg::REG_RAMP_DOWN, pick_length());
                write_reg(tsp_pkg::REG_CURVE_MODE, CFG_DATA_W'($urandom));
            end
            settings_run++;
            phase_base  = points_expected;
            phase_ticks = 0;
            while (points_expected - phase_base < PHASE_POINTS && phase_ticks < PHASE_TICKS) begin
                if (!prof_running) begin
                    start = ($urandom_range(0, 9) != 0);
                end else begin
                    start = ($urandom_range(0, 59) == 0);
                end
                drive_tick(start, WANT_MODEL, none_pt);
                phase_ticks++;
                if ($urandom_range(0, 99) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        mismatches += pending_points.size();
        $display("%0d ticks driven over %0d register settings, %0d register writes",
                 ticks_taken, settings_run, cfg_writes);
        $display("%0d profile points checked, linear and smooth ramps, restarts and empty segments",
                 points_checked);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
